@@ sv/recent_spot_dedup_filter_macros.svh @@
// assertion macros shared by the recent spot filter rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef RECENT_SPOT_DEDUP_FILTER_MACROS_SVH
`define RECENT_SPOT_DEDUP_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define RSDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/rsdf_pkg.sv @@
// shared types and constants for the recent spot filter
// no dependencies; imported by every module of the block
package rsdf_pkg;

   // item kinds carried in req_tuser
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // register indexes of the csr port
   localparam logic [1:0] CSR_HOLD     = 2'd0;
   localparam logic [1:0] CSR_FRACTION = 2'd1;
   localparam logic [1:0] CSR_MIN_SPAN = 2'd2;

   // field widths
   localparam int COORD_W  = 24;
   localparam int RADIUS_W = 16;
   localparam int HOLD_W   = 16;
   localparam int FRAC_W   = 8;
   localparam int SPAN_W   = 16;
   localparam int SPAN2_W  = 32;
   localparam int STAMP_W  = 32;
   localparam int OPND_W   = 25;
   localparam int PROD_W   = 50;

   // port widths
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [HOLD_W-1:0] HOLD_RESET     = 16'd20;
   localparam logic [FRAC_W-1:0] FRACTION_RESET = 8'd87;
   localparam logic [SPAN_W-1:0] MIN_SPAN_RESET = 16'd48;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPAN,
      ST_SQR,
      ST_AX0,
      ST_AX1,
      ST_AX2,
      ST_CHK,
      ST_FETCH,
      ST_WRITE,
      ST_RESP
   } state_type;

   // operand selection of the shared multiplier
   typedef enum logic [1:0] {
      MUL_SPAN,
      MUL_SQR,
      MUL_DIFF
   } mul_op_type;

   // one ring entry
   typedef struct packed {
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
      logic [STAMP_W-1:0] stamp;
   } spot_type;

   // ring memory control
   typedef struct packed {
      logic wr_en;
      logic clear;
   } mem_ctl_type;

endpackage

@@ sv/rsdf_mul_unit.sv @@
// shared multiplier of the recent spot filter: span scaling, span square, axis square
// depends on rsdf_pkg
module rsdf_mul_unit (
   input  rsdf_pkg::mul_op_type                   op,
   input  logic [rsdf_pkg::COORD_W-1:0]           qry_coord,
   input  logic [rsdf_pkg::COORD_W-1:0]           spot_coord,
   input  logic [rsdf_pkg::RADIUS_W-1:0]          radius,
   input  logic [rsdf_pkg::FRAC_W-1:0]            fraction,
   input  logic [rsdf_pkg::SPAN_W-1:0]            span,
   output logic [rsdf_pkg::PROD_W-1:0]            product
);
   import rsdf_pkg::*;

   logic [OPND_W-1:0] diff;
   logic [OPND_W-1:0] diff_mag;
   logic [OPND_W-1:0] opnd_a;
   logic [OPND_W-1:0] opnd_b;

   // magnitude of the signed axis difference, fits 25 bits
   assign diff     = {qry_coord[COORD_W-1], qry_coord} - {spot_coord[COORD_W-1], spot_coord};
   assign diff_mag = diff[OPND_W-1] ? (~diff + OPND_W'(1)) : diff;

   // operand select
   always_comb begin
      unique case (op)
         MUL_SPAN: begin
            opnd_a = OPND_W'(radius);
            opnd_b = OPND_W'(fraction);
         end
         MUL_SQR: begin
            opnd_a = OPND_W'(span);
            opnd_b = OPND_W'(span);
         end
         MUL_DIFF: begin
            opnd_a = diff_mag;
            opnd_b = diff_mag;
         end
         default: begin
            opnd_a = diff_mag;
            opnd_b = diff_mag;
         end
      endcase
   end

   assign product = opnd_a * opnd_b;

endmodule

@@ sv/rsdf_spot_mem.sv @@
// ring of recent spots: position and stamp memory with per-entry valid bits
// depends on rsdf_pkg
module rsdf_spot_mem #(
   parameter int ENTRIES = 16,
   parameter int AW      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsdf_pkg::mem_ctl_type ctl,
   input  logic [AW-1:0]         wr_addr,
   input  rsdf_pkg::spot_type    wr_data,
   input  logic [AW-1:0]         rd_addr,
   output rsdf_pkg::spot_type    rd_data,
   output logic                  rd_valid
);
   import rsdf_pkg::*;

   spot_type           mem_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   spot_type           rd_data_ff;
   logic               rd_valid_ff;

   // valid bits: cleared by reset or clear, set on write
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

@@ sv/recent_spot_dedup_filter.sv @@
// top level of the recent spot filter: sequencer, query datapath and ports
// depends on rsdf_pkg, rsdf_mul_unit, rsdf_spot_mem and the assertion macros
`include "recent_spot_dedup_filter_macros.svh"

// Recent impact spot filter. A tick (tuser 0) bumps the frame counter, a clear
// (tuser 2) empties the ring and zeroes pointer and counter; both finish in the
// cycle they are taken and give no response, as does the unused code 3. An
// impact query (tuser 1) gives exactly one response: tdata bit 0 is 1 when the
// spot was recorded, 0 when a live entry lay within the span. The block is not
// ready while a query is in flight. A query sets up its span in ST_SPAN and
// ST_SQR, then checks the entries in turn: a dead entry in ST_AX0 and ST_FETCH
// (the last one in ST_AX0 alone), a live one in ST_AX0, ST_AX1, ST_AX2 and
// ST_CHK. It stops early on the first match; else it records in ST_WRITE. It
// hands over the response in ST_RESP, waiting while an earlier response is
// still held. The single multiplier handles one axis of one entry per cycle.
module recent_spot_dedup_filter #(
   parameter int ENTRIES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // query channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pos_x[23:0], pos_y[47:24], pos_z[71:48], radius[87:72]
   input  logic [rsdf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // func[1:0]
   input  logic [1:0]                           req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // accepted[0], zero fill above
   output logic [rsdf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [rsdf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rsdf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rsdf_pkg::*;

   localparam int          AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

   // control registers
   state_type            state_ff, state_in;
   logic [HOLD_W-1:0]    hold_ff, hold_in;
   logic [FRAC_W-1:0]    frac_ff, frac_in;
   logic [SPAN_W-1:0]    min_span_ff, min_span_in;
   logic [STAMP_W-1:0]   frame_ff, frame_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [COORD_W-1:0]   qx_ff, qx_in;
   logic [COORD_W-1:0]   qy_ff, qy_in;
   logic [COORD_W-1:0]   qz_ff, qz_in;
   logic [RADIUS_W-1:0]  radius_ff, radius_in;
   logic [SPAN_W-1:0]    span_ff, span_in;
   logic [SPAN2_W-1:0]   span2_ff, span2_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic                 last_ff, last_in;
   logic                 result_ff, result_in;
   logic                 rsp_acc_ff, rsp_acc_in;

   // datapath wiring
   mul_op_type           mul_op;
   logic [COORD_W-1:0]   qry_coord;
   logic [COORD_W-1:0]   spot_coord;
   logic [PROD_W-1:0]    product;
   logic [SPAN_W-1:0]    scaled_span;
   mem_ctl_type          mem_ctl;
   spot_type             wr_spot;
   spot_type             rd_spot;
   logic                 rd_valid;
   logic [STAMP_W-1:0]   age;
   logic                 live;
   logic [PROD_W-1:0]    dist2;
   logic                 match;
   logic                 req_xfer;
   logic                 rsp_free;
   logic [1:0]           func;
   logic [AW-1:0]        idx_next;
   logic [AW-1:0]        ptr_next;

   assign func     = req_tuser;
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // entry liveness and distance check
   assign age         = frame_ff - rd_spot.stamp;
   assign live        = rd_valid && (rd_spot.stamp != '0) && (age <= STAMP_W'(hold_ff));
   assign dist2       = acc_ff + prod_ff;
   assign match       = dist2 <= PROD_W'(span2_ff);
   assign scaled_span = product[SPAN_W+7:8];
   assign idx_next    = (idx_ff == LAST) ? '0 : idx_ff + AW'(1);
   assign ptr_next    = (ptr_ff == LAST) ? '0 : ptr_ff + AW'(1);
   assign wr_spot     = '{z: qz_ff, y: qy_ff, x: qx_ff, stamp: frame_ff};

   rsdf_mul_unit u_mul (
      .op         (mul_op),
      .qry_coord  (qry_coord),
      .spot_coord (spot_coord),
      .radius     (radius_ff),
      .fraction   (frac_ff),
      .span       (span_ff),
      .product    (product)
   );

   rsdf_spot_mem #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .wr_addr  (ptr_ff),
      .wr_data  (wr_spot),
      .rd_addr  (idx_ff),
      .rd_data  (rd_spot),
      .rd_valid (rd_valid)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_xfer && func == FUNC_QUERY) state_in = ST_SPAN;
         ST_SPAN:  state_in = ST_SQR;
         ST_SQR:   state_in = ST_AX0;
         ST_AX0: begin
            priority if (live)            state_in = ST_AX1;
            else if (idx_ff == LAST)      state_in = ST_WRITE;
            else                          state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_AX0;
         ST_AX1:   state_in = ST_AX2;
         ST_AX2:   state_in = ST_CHK;
         ST_CHK: begin
            priority if (match)           state_in = ST_RESP;
            else if (last_ff)             state_in = ST_WRITE;
            else                          state_in = ST_AX0;
         end
         ST_WRITE: state_in = ST_RESP;
         ST_RESP:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      mem_ctl.wr_en = (state_ff == ST_WRITE);
      mem_ctl.clear = req_xfer && (func == FUNC_CLEAR);
      qry_coord     = qx_ff;
      spot_coord    = rd_spot.x;
      unique case (state_ff)
         ST_SPAN: mul_op = MUL_SPAN;
         ST_SQR:  mul_op = MUL_SQR;
         default: mul_op = MUL_DIFF;
      endcase
      unique case (state_ff)
         ST_AX1: begin
            qry_coord  = qy_ff;
            spot_coord = rd_spot.y;
         end
         ST_AX2: begin
            qry_coord  = qz_ff;
            spot_coord = rd_spot.z;
         end
         default: begin
            qry_coord  = qx_ff;
            spot_coord = rd_spot.x;
         end
      endcase
   end

   // register next values
   always_comb begin
      hold_in      = hold_ff;
      frac_in      = frac_ff;
      min_span_in  = min_span_ff;
      frame_in     = frame_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      qz_in        = qz_ff;
      radius_in    = radius_ff;
      span_in      = span_ff;
      span2_in     = span2_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      last_in      = last_ff;
      result_in    = result_ff;
      rsp_acc_in   = rsp_acc_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD:     hold_in     = csr_wdata[HOLD_W-1:0];
            CSR_FRACTION: frac_in     = csr_wdata[FRAC_W-1:0];
            CSR_MIN_SPAN: min_span_in = csr_wdata[SPAN_W-1:0];
            default:      ;
         endcase
      end

      // response transfer frees the output register
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (func)
                  FUNC_TICK:  frame_in = frame_ff + STAMP_W'(1);
                  FUNC_CLEAR: begin
                     frame_in = '0;
                     ptr_in   = '0;
                  end
                  FUNC_QUERY: begin
                     qx_in     = req_tdata[23:0];
                     qy_in     = req_tdata[47:24];
                     qz_in     = req_tdata[71:48];
                     radius_in = req_tdata[87:72];
                     idx_in    = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SPAN:  span_in  = (scaled_span < min_span_ff) ? min_span_ff : scaled_span;
         ST_SQR:   span2_in = product[SPAN2_W-1:0];
         ST_AX0: begin
            prod_in = product;
            if (!live) idx_in = idx_next;
         end
         ST_AX1: begin
            prod_in = product;
            acc_in  = prod_ff;
         end
         ST_AX2: begin
            prod_in = product;
            acc_in  = acc_ff + prod_ff;
            last_in = (idx_ff == LAST);
            idx_in  = idx_next;
         end
         ST_CHK:   result_in = !match;
         ST_WRITE: begin
            result_in = 1'b1;
            ptr_in    = ptr_next;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = result_ff;
            end
         end
         ST_FETCH: ;
         default:  ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hold_ff      <= HOLD_RESET;
         frac_ff      <= FRACTION_RESET;
         min_span_ff  <= MIN_SPAN_RESET;
         frame_ff     <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_ff      <= hold_in;
         frac_ff      <= frac_in;
         min_span_ff  <= min_span_in;
         frame_ff     <= frame_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      qz_ff      <= qz_in;
      radius_ff  <= radius_in;
      span_ff    <= span_in;
      span2_ff   <= span2_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      last_ff    <= last_in;
      result_ff  <= result_in;
      rsp_acc_ff <= rsp_acc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-1)'(0), rsp_acc_ff};

   // checks on the sequencer and counters
   `RSDF_ASSERT_NEXT(a_query_starts, clock, reset,
      req_xfer && func == FUNC_QUERY, state_ff == ST_SPAN,
      "query transfer did not start the span setup")
   `RSDF_ASSERT_NEXT(a_tick_counts, clock, reset,
      req_xfer && func == FUNC_TICK, frame_ff == $past(frame_ff) + STAMP_W'(1),
      "tick did not advance the frame counter")
   `RSDF_ASSERT_NEXT(a_ptr_moves, clock, reset,
      state_ff == ST_WRITE, ptr_ff != $past(ptr_ff),
      "ring pointer did not advance on record")
   `RSDF_ASSERT_NOW(a_idx_range, clock, reset,
      1'b1, idx_ff <= LAST && ptr_ff <= LAST,
      "ring index beyond the last entry")

endmodule

@@ tb/tb_recent_spot_dedup_filter.sv @@
// self-checking testbench for recent_spot_dedup_filter: directed and random impact traffic
// depends on rsdf_pkg and the recent_spot_dedup_filter rtl; a local spot table predicts verdicts
module tb_recent_spot_dedup_filter;
   timeunit 1ns;
   timeprecision 1ps;

   import rsdf_pkg::*;

   localparam int SPOTS = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES = 80;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS = 280;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [23:0] COORD_MAX = 24'h7FFFFF;
   localparam logic [23:0] COORD_MIN = 24'h800000;

   typedef struct {
      logic [1:0]  func;
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
      logic [15:0] radius;
   } spot_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = FUNC_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // stimulus and scoreboard
   spot_req_type impact_feed[$];
   spot_req_type drive_item;
   bit expected_verdicts[$];
   bit got_verdict;
   int fail_count = 0;
   int idle_pct = 12;
   int stall_cycles = 0;
   logic [23:0] hot_x[4];
   logic [23:0] hot_y[4];
   logic [23:0] hot_z[4];

   // predicted spot table and registers
   logic [23:0] seen_x[SPOTS] = '{default: '0};
   logic [23:0] seen_y[SPOTS] = '{default: '0};
   logic [23:0] seen_z[SPOTS] = '{default: '0};
   logic [31:0] seen_stamp[SPOTS] = '{default: '0};
   int next_slot = 0;
   logic [31:0] frame_no = '0;
   logic [HOLD_W-1:0] cfg_hold = HOLD_RESET;
   logic [FRAC_W-1:0] cfg_frac = FRACTION_RESET;
   logic [SPAN_W-1:0] cfg_min_span = MIN_SPAN_RESET;

   recent_spot_dedup_filter #(.ENTRIES(SPOTS)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic spot_req_type spot_item(input logic [1:0] func, input logic [23:0] x,
                                              input logic [23:0] y, input logic [23:0] z,
                                              input logic [15:0] radius);
      spot_req_type it;
      it.func = func;
      it.x = x;
      it.y = y;
      it.z = z;
      it.radius = radius;
      return it;
   endfunction

   // apply one accepted item to the local table, queue a verdict for queries
   task automatic predict_spot_verdict(input logic [1:0] func, input logic [REQ_DATA_W-1:0] data);
      longint dx, dy, dz, span, span_sq, dist_sq;
      logic [31:0] age;
      bit matched;
      matched = 1'b0;
      case (func)
         FUNC_TICK: begin
            frame_no = frame_no + 32'd1;
         end
         FUNC_CLEAR: begin
            seen_x = '{default: '0};
            seen_y = '{default: '0};
            seen_z = '{default: '0};
            seen_stamp = '{default: '0};
            next_slot = 0;
            frame_no = '0;
         end
         FUNC_QUERY: begin
            span = (longint'(data[87:72]) * longint'(cfg_frac)) >> 8;
            if (span < longint'(cfg_min_span)) span = longint'(cfg_min_span);
            span_sq = span * span;
            for (int i = 0; i < SPOTS && !matched; i++) begin
               age = frame_no - seen_stamp[i];
               if (seen_stamp[i] != 0 && age <= 32'(cfg_hold)) begin
                  dx = longint'($signed(data[23:0])) - longint'($signed(seen_x[i]));
                  dy = longint'($signed(data[47:24])) - longint'($signed(seen_y[i]));
                  dz = longint'($signed(data[71:48])) - longint'($signed(seen_z[i]));
                  dist_sq = dx * dx + dy * dy + dz * dz;
                  if (dist_sq <= span_sq) matched = 1'b1;
               end
            end
            if (!matched) begin
               seen_x[next_slot] = data[23:0];
               seen_y[next_slot] = data[47:24];
               seen_z[next_slot] = data[71:48];
               seen_stamp[next_slot] = frame_no;
               next_slot = (next_slot + 1) % SPOTS;
            end
            expected_verdicts.push_back(!matched);
         end
         default: ;
      endcase
   endtask

   // random item: mostly queries clustered on a few hot spots, plus ticks and noise
   function automatic spot_req_type random_item();
      spot_req_type it;
      int roll, hot, spread;
      roll = $urandom_range(99);
      hot = $urandom_range(3);
      it = spot_item(FUNC_QUERY, 24'($urandom()), 24'($urandom()), 24'($urandom()),
                     16'($urandom()));
      if (roll < 30) begin
         it.func = FUNC_TICK;
      end else if (roll < 32) begin
         it.func = FUNC_CLEAR;
      end else if (roll < 34) begin
         it.func = FUNC_UNUSED;
      end else if (roll < 86) begin
         case ($urandom_range(3))
            0: spread = 16;
            1: spread = 80;
            2: spread = 600;
            default: spread = 4000;
         endcase
         it.x = hot_x[hot] + 24'(int'($urandom_range(2 * spread)) - spread);
         it.y = hot_y[hot] + 24'(int'($urandom_range(2 * spread)) - spread);
         it.z = hot_z[hot] + 24'(int'($urandom_range(2 * spread)) - spread);
         case ($urandom_range(3))
            0: it.radius = '0;
            1: it.radius = 16'($urandom_range(1500));
            2: it.radius = 16'($urandom_range(300));
            default: it.radius = 16'($urandom_range(65535));
         endcase
      end
      return it;
   endfunction

   // wait until every item is taken and every verdict has come back;
   // checked on the falling edge so the driver and monitor updates have landed
   task automatic settle();
      while (impact_feed.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write while the block is idle; the local copy follows it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_HOLD: cfg_hold = val;
         CSR_FRACTION: cfg_frac = val[FRAC_W-1:0];
         CSR_MIN_SPAN: cfg_min_span = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < 4; i++) begin
         hot_x[i] = 24'($urandom());
         hot_y[i] = 24'($urandom());
         hot_z[i] = 24'($urandom());
      end
      for (int i = 0; i < count; i++) impact_feed.push_back(random_item());
      settle();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (impact_feed.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
            drive_item = impact_feed.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= drive_item.func;
            req_tdata <= {drive_item.radius, drive_item.z, drive_item.y, drive_item.x};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: check the response transfer first, then predict from the request transfer
   always @(posedge clock) begin
      rsp_tready <= int'($urandom_range(99)) >= idle_pct;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with no query pending, accepted=%0b",
                           $realtime, rsp_tdata[0]);
            end else begin
               got_verdict = expected_verdicts.pop_front();
               if (rsp_tdata[0] !== got_verdict) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: accepted mismatch, expected %0b got %0b",
                              $realtime, got_verdict, rsp_tdata[0]);
               end
            end
         end
         if (req_tvalid && req_tready) predict_spot_verdict(req_tuser, req_tdata);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, stall_cycles);
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default registers: frame zero stamps, exact span boundary, extremes, clear
      impact_feed.push_back(spot_item(FUNC_QUERY, '0, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, '0, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_TICK, '0, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, 24'd100, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, 24'd148, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, 24'd149, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF));
      impact_feed.push_back(spot_item(FUNC_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 16'hFFFF));
      impact_feed.push_back(spot_item(FUNC_UNUSED, 24'hA5A5A5, 24'h5A5A5A, 24'hFFFFFF, 16'hFFFF));
      impact_feed.push_back(spot_item(FUNC_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, '0));
      impact_feed.push_back(spot_item(FUNC_CLEAR, '0, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, '0));
      impact_feed.push_back(spot_item(FUNC_TICK, '0, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, '0));
      settle();
      run_random(RANDOM_ITEMS);

      // zero hold and zero floor: an entry is live only in its own frame
      write_reg(CSR_HOLD, 16'd0);
      write_reg(CSR_FRACTION, 16'd255);
      write_reg(CSR_MIN_SPAN, 16'd0);
      impact_feed.push_back(spot_item(FUNC_TICK, '0, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, 24'h012345, 24'hFFFFFB, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, 24'h012345, 24'hFFFFFB, '0, '0));
      impact_feed.push_back(spot_item(FUNC_TICK, '0, '0, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, 24'h012345, 24'hFFFFFB, '0, '0));
      impact_feed.push_back(spot_item(FUNC_QUERY, 24'h012345, 24'hFFFFFB, '0, 16'hFFFF));
      settle();
      run_random(RANDOM_ITEMS);

      // longest hold, widest floor, radius scaling off
      write_reg(CSR_HOLD, 16'hFFFF);
      write_reg(CSR_FRACTION, 16'd0);
      write_reg(CSR_MIN_SPAN, 16'hFFFF);
      run_random(RANDOM_ITEMS);

      // short hold; fraction written with upper bits set, unused index ignored
      write_reg(CSR_HOLD, 16'd5);
      write_reg(CSR_FRACTION, 16'h3A80);
      write_reg(CSR_MIN_SPAN, 16'd200);
      write_reg(CSR_UNUSED, 16'hFFFF);
      run_random(RANDOM_ITEMS);

      // back-to-back stretch with no idling on either side
      write_reg(CSR_HOLD, 16'd40);
      write_reg(CSR_FRACTION, 16'd87);
      write_reg(CSR_MIN_SPAN, 16'd48);
      idle_pct = 0;
      run_random(RANDOM_ITEMS);
      idle_pct = 12;
      run_random(RANDOM_ITEMS / 4);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         fail_count += expected_verdicts.size();
         $display("%0d expected responses never arrived", expected_verdicts.size());
      end
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/rsdf_pkg.sv
sv/rsdf_mul_unit.sv
sv/rsdf_spot_mem.sv
sv/recent_spot_dedup_filter.sv
tb/tb_recent_spot_dedup_filter.sv
